[rtl/core/frx_pkg.sv]
// frx_pkg: shared types and constants for the framed packet receiver
// holds the result record, result kinds and configuration register indexes
// no dependencies

package frx_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStartByte = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgEndByte = 2'd2;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  localparam logic [ByteW-1:0] StartByteReset = 8'd2;
  localparam logic [ByteW-1:0] EndByteReset = 8'd3;

  typedef struct packed {
    logic             result_kind;
    logic [ByteW-1:0] payload_byte;
    logic [WordW-1:0] payload_index;
    logic             frame_ok;
    logic             end_ok;
    logic             checksum_ok;
    logic             seq_match;
    logic [ByteW-1:0] header;
    logic [WordW-1:0] seq_number;
    logic [ByteW-1:0] direction;
    logic [ByteW-1:0] error_code;
    logic [WordW-1:0] length;
  } result_t;

endpackage

[rtl/core/framed_packet_receiver.sv]
// framed_packet_receiver: byte-wise frame parser with additive checksum
// depends on frx_pkg for the result record and register indexes
//
// Takes one received byte per transfer on the input channel and can take a new
// byte every clock cycle while in_stall is low. Each byte is parsed in the
// cycle it is accepted; a result (a streamed payload byte, or the end-of-frame
// verdict) is registered into the output register, or into the skid entry if
// the output is stalled. An output register plus one skid entry decouple the
// two sides, so input stall rises only while the skid entry is occupied. Bytes
// accepted while enable is low are consumed without effect. The configuration
// port is always ready; writes to indexes beyond end_byte are ignored.

module framed_packet_receiver (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [frx_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [frx_pkg::ByteW-1:0]    cfg_data,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [frx_pkg::ByteW-1:0]    rx_byte,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         result_kind,
  output logic [frx_pkg::ByteW-1:0]    payload_byte,
  output logic [frx_pkg::WordW-1:0]    payload_index,
  output logic                         frame_ok,
  output logic                         end_ok,
  output logic                         checksum_ok,
  output logic                         seq_match,
  output logic [frx_pkg::ByteW-1:0]    header,
  output logic [frx_pkg::WordW-1:0]    seq_number,
  output logic [frx_pkg::ByteW-1:0]    direction,
  output logic [frx_pkg::ByteW-1:0]    error_code,
  output logic [frx_pkg::WordW-1:0]    length
);

  typedef enum logic [3:0] {
    ST_START  = 4'd0,
    ST_HEADER = 4'd1,
    ST_SEQ_L  = 4'd2,
    ST_SEQ_H  = 4'd3,
    ST_DIR    = 4'd4,
    ST_ERR    = 4'd5,
    ST_LEN_L  = 4'd6,
    ST_LEN_H  = 4'd7,
    ST_DATA   = 4'd8,
    ST_SUM    = 4'd9,
    ST_END    = 4'd10
  } parse_state_t;

  logic                       enable;
  logic [frx_pkg::ByteW-1:0]  start_byte;
  logic [frx_pkg::ByteW-1:0]  end_byte;

  parse_state_t               parse_state, parse_state_next;
  logic [frx_pkg::ByteW-1:0]  running_sum, running_sum_next;
  logic [frx_pkg::ByteW-1:0]  header_reg, header_reg_next;
  logic [frx_pkg::WordW-1:0]  seq_reg, seq_reg_next;
  logic [frx_pkg::ByteW-1:0]  direction_reg, direction_reg_next;
  logic [frx_pkg::ByteW-1:0]  error_reg, error_reg_next;
  logic [frx_pkg::WordW-1:0]  length_reg, length_reg_next;
  logic [frx_pkg::WordW-1:0]  byte_index, byte_index_next;
  logic [frx_pkg::ByteW-1:0]  received_sum, received_sum_next;
  logic [frx_pkg::WordW-1:0]  expected_seq, expected_seq_next;

  logic                       in_take;
  logic                       res_valid;
  frx_pkg::result_t           res;
  logic [frx_pkg::WordW-1:0]  index_inc;
  logic                       e_ok, c_ok, f_ok;

  frx_pkg::result_t           out_reg;
  frx_pkg::result_t           skid_reg;
  logic                       skid_valid;
  logic                       out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign in_take   = in_valid && !skid_valid;
  assign out_free  = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      start_byte <= frx_pkg::StartByteReset;
      end_byte   <= frx_pkg::EndByteReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        frx_pkg::CfgEnable:    enable     <= cfg_data[0];
        frx_pkg::CfgStartByte: start_byte <= cfg_data;
        frx_pkg::CfgEndByte:   end_byte   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign index_inc = byte_index + frx_pkg::WordW'(1);
  assign e_ok      = (rx_byte == end_byte);
  assign c_ok      = (running_sum == received_sum);
  assign f_ok      = e_ok && c_ok;

  // parser next state and result
  always_comb begin
    parse_state_next   = parse_state;
    running_sum_next   = running_sum;
    header_reg_next    = header_reg;
    seq_reg_next       = seq_reg;
    direction_reg_next = direction_reg;
    error_reg_next     = error_reg;
    length_reg_next    = length_reg;
    byte_index_next    = byte_index;
    received_sum_next  = received_sum;
    expected_seq_next  = expected_seq;
    res_valid          = 1'b0;
    res                = '0;

    if (in_take && enable) begin
      unique case (parse_state)
        ST_START: begin
          if (rx_byte == start_byte) begin
            parse_state_next = ST_HEADER;
            running_sum_next = '0;
            byte_index_next  = '0;
          end
        end
        ST_HEADER: begin
          header_reg_next  = rx_byte;
          running_sum_next = running_sum + rx_byte;
          parse_state_next = ST_SEQ_L;
        end
        ST_SEQ_L: begin
          seq_reg_next     = {{(frx_pkg::WordW-frx_pkg::ByteW){1'b0}}, rx_byte};
          running_sum_next = running_sum + rx_byte;
          parse_state_next = ST_SEQ_H;
        end
        ST_SEQ_H: begin
          seq_reg_next     = {rx_byte, seq_reg[frx_pkg::ByteW-1:0]};
          running_sum_next = running_sum + rx_byte;
          parse_state_next = ST_DIR;
        end
        ST_DIR: begin
          direction_reg_next = rx_byte;
          running_sum_next   = running_sum + rx_byte;
          parse_state_next   = ST_ERR;
        end
        ST_ERR: begin
          error_reg_next   = rx_byte;
          running_sum_next = running_sum + rx_byte;
          parse_state_next = ST_LEN_L;
        end
        ST_LEN_L: begin
          length_reg_next  = {{(frx_pkg::WordW-frx_pkg::ByteW){1'b0}}, rx_byte};
          running_sum_next = running_sum + rx_byte;
          parse_state_next = ST_LEN_H;
        end
        ST_LEN_H: begin
          length_reg_next  = {rx_byte, length_reg[frx_pkg::ByteW-1:0]};
          running_sum_next = running_sum + rx_byte;
          parse_state_next = ({rx_byte, length_reg[frx_pkg::ByteW-1:0]} != '0) ?
                             ST_DATA : ST_SUM;
        end
        ST_DATA: begin
          res_valid         = 1'b1;
          res.result_kind   = frx_pkg::KindPayload;
          res.payload_byte  = rx_byte;
          res.payload_index = byte_index;
          running_sum_next  = running_sum + rx_byte;
          byte_index_next   = index_inc;
          if (index_inc == length_reg) begin
            parse_state_next = ST_SUM;
          end
        end
        ST_SUM: begin
          received_sum_next = rx_byte;
          parse_state_next  = ST_END;
        end
        ST_END: begin
          res_valid       = 1'b1;
          res.result_kind = frx_pkg::KindVerdict;
          res.frame_ok    = f_ok;
          res.end_ok      = e_ok;
          res.checksum_ok = c_ok;
          res.seq_match   = (seq_reg == expected_seq);
          res.header      = header_reg;
          res.seq_number  = seq_reg;
          res.direction   = direction_reg;
          res.error_code  = error_reg;
          res.length      = length_reg;
          if (f_ok) begin
            expected_seq_next = seq_reg + frx_pkg::WordW'(1);
          end
          parse_state_next = ST_START;
        end
        default: begin
          parse_state_next = ST_START;
        end
      endcase
    end
  end

  // parser state, output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= ST_START;
      running_sum   <= '0;
      header_reg    <= '0;
      seq_reg       <= '0;
      direction_reg <= '0;
      error_reg     <= '0;
      length_reg    <= '0;
      byte_index    <= '0;
      received_sum  <= '0;
      expected_seq  <= '0;
      out_valid     <= 1'b0;
      skid_valid    <= 1'b0;
    end else begin
      parse_state   <= parse_state_next;
      running_sum   <= running_sum_next;
      header_reg    <= header_reg_next;
      seq_reg       <= seq_reg_next;
      direction_reg <= direction_reg_next;
      error_reg     <= error_reg_next;
      length_reg    <= length_reg_next;
      byte_index    <= byte_index_next;
      received_sum  <= received_sum_next;
      expected_seq  <= expected_seq_next;
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
          out_reg    <= skid_reg;
        end else begin
          out_valid <= res_valid;
          if (res_valid) begin
            out_reg <= res;
          end
        end
      end else if (res_valid) begin
        skid_valid <= 1'b1;
        skid_reg   <= res;
      end
    end
  end

  assign result_kind   = out_reg.result_kind;
  assign payload_byte  = out_reg.payload_byte;
  assign payload_index = out_reg.payload_index;
  assign frame_ok      = out_reg.frame_ok;
  assign end_ok        = out_reg.end_ok;
  assign checksum_ok   = out_reg.checksum_ok;
  assign seq_match     = out_reg.seq_match;
  assign header        = out_reg.header;
  assign seq_number    = out_reg.seq_number;
  assign direction     = out_reg.direction;
  assign error_code    = out_reg.error_code;
  assign length        = out_reg.length;

endmodule
